// File: hdl/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg - calendar date advance shared definitions
// Command codes, status codes, calendar constants and the microcode program
// that sequences the date datapath.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // Commands carried by a transaction
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_COMPARE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MONTH = 3'd1,
    ST_BAD_YEAR  = 3'd2,
    ST_BAD_DAY   = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  // Calendar limits
  localparam logic [11:0] YEAR_MIN   = 12'd1900;
  localparam logic [11:0] YEAR_MAX   = 12'd2100;
  localparam logic [11:0] YEAR_RST   = 12'd1900;
  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;
  localparam logic [4:0]  DAY_FIRST  = 5'd1;
  localparam logic [4:0]  DAY_LEAP   = 5'd29;
  localparam logic [4:0]  DAY_LAST   = 5'd31;

  // Reciprocal of 100 scaled by 2^19, exact floor for 12-bit years
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int unsigned RECIP_SH   = 19;
  localparam logic [6:0]  HUNDRED    = 7'd100;

  // Datapath actions
  typedef enum logic [2:0] {
    ACT_NOP      = 3'd0,
    ACT_CHK_MY   = 3'd1,  // check month and year, compute leap of argument year
    ACT_MLEN_ARG = 3'd2,  // month length of argument month
    ACT_LOAD     = 3'd3,  // check day, store date
    ACT_LEAP_CUR = 3'd4,  // leap flag of stored year
    ACT_MLEN_CUR = 3'd5,  // month length of stored month
    ACT_STEP     = 3'd6,  // advance one day
    ACT_CMP      = 3'd7   // compare stored date with argument
  } act_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER   = 3'd0,
    COND_ALWAYS  = 3'd1,
    COND_BAD_MY  = 3'd2,
    COND_ADV_END = 3'd3,
    COND_STAY    = 3'd4,
    COND_FINISH  = 3'd5   // publish and leave the program
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Program addresses
  localparam upc_t PC_LOAD0 = 4'd0;
  localparam upc_t PC_LOAD1 = 4'd1;
  localparam upc_t PC_LOAD2 = 4'd2;
  localparam upc_t PC_ADV0  = 4'd3;
  localparam upc_t PC_ADV1  = 4'd4;
  localparam upc_t PC_ADV2  = 4'd5;
  localparam upc_t PC_ADV3  = 4'd6;
  localparam upc_t PC_CMP0  = 4'd7;
  localparam upc_t PC_FIN   = 4'd8;

  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    case (pc)
      PC_LOAD0: w = '{ACT_CHK_MY,   COND_BAD_MY,  PC_FIN};
      PC_LOAD1: w = '{ACT_MLEN_ARG, COND_NEVER,   PC_FIN};
      PC_LOAD2: w = '{ACT_LOAD,     COND_ALWAYS,  PC_FIN};
      PC_ADV0:  w = '{ACT_LEAP_CUR, COND_ADV_END, PC_FIN};
      PC_ADV1:  w = '{ACT_MLEN_CUR, COND_NEVER,   PC_FIN};
      PC_ADV2:  w = '{ACT_STEP,     COND_STAY,    PC_ADV2};
      PC_ADV3:  w = '{ACT_NOP,      COND_ALWAYS,  PC_ADV0};
      PC_CMP0:  w = '{ACT_CMP,      COND_ALWAYS,  PC_FIN};
      PC_FIN:   w = '{ACT_NOP,      COND_FINISH,  PC_FIN};
      default:  w = '{ACT_NOP,      COND_FINISH,  PC_FIN};
    endcase
    return w;
  endfunction

  // Leap year: divisible by 4 and not by 100, or divisible by 400
  function automatic logic is_leap(input logic [11:0] y);
    logic [24:0] prod;
    logic [5:0]  q;
    logic [11:0] q100;
    prod = 25'(y) * 25'(RECIP_100);
    q    = prod[RECIP_SH +: 6];
    q100 = 12'(q) * 12'(HUNDRED);
    return (y[1:0] == 2'b00) && ((y != q100) || (q[1:0] == 2'b00));
  endfunction

  // Days in month; zero for a code that is not a month
  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAY_LAST;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      MONTH_FEB:                                   d = leap ? DAY_LEAP : 5'd28;
      default:                                     d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// File: hdl/calendar_date_advance_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_advance_unit - Gregorian date register with load/advance/compare
// Holds one date in 1900..2100 and answers one result per command transaction.
// ----------------------------------------------------------------------------
// One transaction at a time runs through a short microcode program that drives
// a small date datapath. Load checks month and year, looks up the month length,
// then checks the day and stores the date; a bad month or year skips straight
// to the final step. Compare sets the earlier flag, and the unused command goes
// straight to the final step. In advance the step unit moves one day per cycle
// and, at each month change, stops to refresh the leap flag and month length.
// Up to 65535 days may be requested. The result sits in an output register,
// so the next transaction is taken as soon as the program ends even while the
// previous result is stalled; a new result waits in the final step until the
// output register frees up. After reset the stored date is 1 January 1900.
module calendar_date_advance_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_day,
  input  logic [3:0]  in_month,
  input  logic [11:0] in_year,
  input  logic [15:0] in_day_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [11:0] out_year,
  output logic [2:0]  out_status,
  output logic        out_is_earlier
);
  import cda_pkg::*;

  // Sequencer
  logic        busy_r, busy_nxt;
  upc_t        upc_r, upc_nxt;
  uword_t      uw;

  // Stored date
  logic [4:0]  cur_day_r, cur_day_nxt;
  logic [3:0]  cur_month_r, cur_month_nxt;
  logic [11:0] cur_year_r, cur_year_nxt;

  // Transaction arguments and working registers
  logic [4:0]  arg_day_r;
  logic [3:0]  arg_month_r;
  logic [11:0] arg_year_r;
  logic [15:0] cnt_r, cnt_nxt;
  logic        leap_r, leap_nxt;
  logic [4:0]  mlen_r, mlen_nxt;
  status_t     status_r, status_nxt;
  logic        earlier_r, earlier_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  out_day_r;
  logic [3:0]  out_month_r;
  logic [11:0] out_year_r;
  logic [2:0]  out_status_r;
  logic        out_earlier_r;

  logic in_acc, pub_ok, pub, bad_month, bad_year, bad_day, day_inc, take_jump;

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign pub_ok   = !out_valid_r || !out_stall;

  assign uw = ucode_rom(upc_r);

  assign bad_month = (arg_month_r < MONTH_JAN) || (arg_month_r > MONTH_DEC);
  assign bad_year  = (arg_year_r < YEAR_MIN) || (arg_year_r > YEAR_MAX);
  assign bad_day   = (arg_day_r == 5'd0) || (arg_day_r > mlen_r);
  // A step that only bumps the day keeps the month length valid
  assign day_inc   = cur_day_r < mlen_r;

  // Evaluate the jump condition of the current control word
  always_comb begin
    case (uw.cond)
      COND_NEVER:   take_jump = 1'b0;
      COND_ALWAYS:  take_jump = 1'b1;
      COND_BAD_MY:  take_jump = bad_month || bad_year;
      COND_ADV_END: take_jump = (cnt_r == 16'd0) || (status_r == ST_OVERFLOW);
      COND_STAY:    take_jump = day_inc && (cnt_r != 16'd1);
      COND_FINISH:  take_jump = 1'b0;
      default:      take_jump = 1'b0;
    endcase
  end

  assign pub = busy_r && (uw.cond == COND_FINISH) && pub_ok;

  // Sequencing and datapath
  always_comb begin
    busy_nxt      = busy_r;
    upc_nxt       = upc_r;
    cur_day_nxt   = cur_day_r;
    cur_month_nxt = cur_month_r;
    cur_year_nxt  = cur_year_r;
    cnt_nxt       = cnt_r;
    leap_nxt      = leap_r;
    mlen_nxt      = mlen_r;
    status_nxt    = status_r;
    earlier_nxt   = earlier_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (in_acc) begin
      // Start a transaction: clear results, dispatch on the command
      busy_nxt    = 1'b1;
      cnt_nxt     = in_day_count;
      status_nxt  = ST_OK;
      earlier_nxt = 1'b0;
      case (cmd_t'(in_command))
        CMD_LOAD:    upc_nxt = PC_LOAD0;
        CMD_ADVANCE: upc_nxt = PC_ADV0;
        CMD_COMPARE: upc_nxt = PC_CMP0;
        default:     upc_nxt = PC_FIN;
      endcase
    end else if (busy_r) begin
      case (uw.act)
        ACT_CHK_MY: begin
          if (bad_month) begin
            status_nxt = ST_BAD_MONTH;
          end else if (bad_year) begin
            status_nxt = ST_BAD_YEAR;
          end
          leap_nxt = is_leap(arg_year_r);
        end
        ACT_MLEN_ARG: begin
          mlen_nxt = month_length(arg_month_r, leap_r);
        end
        ACT_LOAD: begin
          if (bad_day) begin
            status_nxt = ST_BAD_DAY;
          end else begin
            cur_day_nxt   = arg_day_r;
            cur_month_nxt = arg_month_r;
            cur_year_nxt  = arg_year_r;
          end
        end
        ACT_LEAP_CUR: begin
          leap_nxt = is_leap(cur_year_r);
        end
        ACT_MLEN_CUR: begin
          mlen_nxt = month_length(cur_month_r, leap_r);
        end
        ACT_STEP: begin
          if (day_inc) begin
            cur_day_nxt = cur_day_r + 5'd1;
            cnt_nxt     = cnt_r - 16'd1;
          end else if (cur_month_r < MONTH_DEC) begin
            cur_day_nxt   = DAY_FIRST;
            cur_month_nxt = cur_month_r + 4'd1;
            cnt_nxt       = cnt_r - 16'd1;
          end else if (cur_year_r >= YEAR_MAX) begin
            // Saturate at the last day of the range
            status_nxt = ST_OVERFLOW;
          end else begin
            cur_day_nxt   = DAY_FIRST;
            cur_month_nxt = MONTH_JAN;
            cur_year_nxt  = cur_year_r + 12'd1;
            cnt_nxt       = cnt_r - 16'd1;
          end
        end
        ACT_CMP: begin
          earlier_nxt = (cur_year_r < arg_year_r) ||
                        ((cur_year_r == arg_year_r) && (cur_month_r < arg_month_r)) ||
                        ((cur_year_r == arg_year_r) && (cur_month_r == arg_month_r) &&
                         (cur_day_r < arg_day_r));
        end
        default: begin
        end
      endcase

      if (uw.cond == COND_FINISH) begin
        // Hold in the final step until the output register frees up
        if (pub_ok) begin
          busy_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
      end else if (take_jump) begin
        upc_nxt = uw.target;
      end else begin
        upc_nxt = upc_r + upc_t'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      upc_r       <= PC_FIN;
      out_valid_r <= 1'b0;
      cur_day_r   <= DAY_FIRST;
      cur_month_r <= MONTH_JAN;
      cur_year_r  <= YEAR_RST;
      status_r    <= ST_OK;
    end else begin
      busy_r      <= busy_nxt;
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_month_r <= cur_month_nxt;
      cur_year_r  <= cur_year_nxt;
      status_r    <= status_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    leap_r    <= leap_nxt;
    mlen_r    <= mlen_nxt;
    earlier_r <= earlier_nxt;
    if (in_acc) begin
      arg_day_r   <= in_day;
      arg_month_r <= in_month;
      arg_year_r  <= in_year;
    end
    if (pub) begin
      out_day_r     <= cur_day_r;
      out_month_r   <= cur_month_r;
      out_year_r    <= cur_year_r;
      out_status_r  <= status_r;
      out_earlier_r <= earlier_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_day        = out_day_r;
  assign out_month      = out_month_r;
  assign out_year       = out_year_r;
  assign out_status     = out_status_r;
  assign out_is_earlier = out_earlier_r;

`ifndef SYNTHESIS
  // Stored date always stays a legal date inside the range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_month_r >= MONTH_JAN) && (cur_month_r <= MONTH_DEC) &&
    (cur_year_r >= YEAR_MIN) && (cur_year_r <= YEAR_MAX) && (cur_day_r != 5'd0))
    else $error("stored date out of range");

  // Overflow only ever leaves the date at the last day of the range
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (status_r == ST_OVERFLOW)) |->
    ((cur_day_r == DAY_LAST) && (cur_month_r == MONTH_DEC) && (cur_year_r == YEAR_MAX)))
    else $error("overflow without saturated date");

  // The stored date moves only while a transaction runs
  a_date_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !in_acc) |=>
    ($stable(cur_day_r) && $stable(cur_month_r) && $stable(cur_year_r)))
    else $error("stored date changed while idle");

  // A compare flag is only reported with an ok status
  a_earlier_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_earlier_r) |-> (out_status_r == ST_OK))
    else $error("compare flag with error status");
`endif

endmodule
